[rtl/rwp_pkg.sv]
package rwp_pkg;

   // chunk ids as gathered little-endian into a 32-bit word
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [31:0] FMT_BYTES    = 32'd16;
   localparam logic [15:0] FMT_PCM      = 16'd1;

   // parse phases
   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_WAVE   = 3'd1;
   localparam logic [2:0] PH_FMT    = 3'd2;
   localparam logic [2:0] PH_DATA   = 3'd3;
   localparam logic [2:0] PH_SKIP   = 3'd4;

   // byte positions inside a phase
   localparam logic [4:0] IDX_TAG_END   = 5'd3;
   localparam logic [4:0] IDX_HDR_END   = 5'd7;
   localparam logic [4:0] IDX_WAVE_END  = 5'd3;
   localparam logic [4:0] IDX_FMT_CODE  = 5'd1;
   localparam logic [4:0] IDX_FMT_CHAN  = 5'd3;
   localparam logic [4:0] IDX_FMT_RATE  = 5'd7;
   localparam logic [4:0] IDX_FMT_BRATE = 5'd11;
   localparam logic [4:0] IDX_FMT_ALIGN = 5'd13;
   localparam logic [4:0] IDX_FMT_LAST  = 5'd15;

   // result kinds
   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_FORMAT = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // error codes
   localparam logic [2:0] ERR_NOT_WAVE  = 3'd0;
   localparam logic [2:0] ERR_NOT_PCM   = 3'd1;
   localparam logic [2:0] ERR_ODD_BITS  = 3'd2;
   localparam logic [2:0] ERR_BYTE_RATE = 3'd3;
   localparam logic [2:0] ERR_ALIGN     = 3'd4;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       start_req;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] sample;
      logic [15:0]        channels;
      logic [31:0]        sample_rate;
      logic [15:0]        bit_depth;
      logic [2:0]         error_code;
   } rsp_type;

   // outcome of the fmt check sequencer
   typedef struct packed {
      logic       busy;
      logic       done;
      logic       pass;
      logic [2:0] err;
   } chk_res_type;

endpackage

[rtl/rwp_fmt_check.sv]
module rwp_fmt_check (
   input  logic                clock,
   input  logic                reset,
   input  logic                launch,
   input  logic [15:0]         channels,
   input  logic [31:0]         rate,
   input  logic [15:0]         bits,
   input  logic [31:0]         byte_rate,
   input  logic [15:0]         align,
   output rwp_pkg::chk_res_type res
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_BLK  = 2'd1;
   localparam logic [1:0] S_PROD = 2'd2;
   localparam logic [1:0] S_CMP  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [31:0] blk_ff, blk_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] mul_a, mul_b;
   logic [31:0] mul_lo;

   // shared multiplier, low word only
   always_comb begin
      if (state_ff == S_PROD) begin
         mul_a = rate;
         mul_b = blk_ff;
      end else begin
         mul_a = {16'd0, channels};
         mul_b = {16'd0, bits};
      end
   end

   assign mul_lo = mul_a * mul_b;

   // sequencer: block product, then rate product, then compare
   always_comb begin
      state_in = state_ff;
      blk_in   = blk_ff;
      prod_in  = prod_ff;
      case (state_ff)
         S_IDLE: begin
            if (launch) begin
               state_in = S_BLK;
            end
         end
         S_BLK: begin
            blk_in   = mul_lo;
            state_in = S_PROD;
         end
         S_PROD: begin
            prod_in  = mul_lo;
            state_in = S_CMP;
         end
         S_CMP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      blk_ff  <= blk_in;
      prod_ff <= prod_in;
   end

   // checks in order: odd bits, byte rate, block align
   always_comb begin
      res.busy = (state_ff != S_IDLE);
      res.done = (state_ff == S_CMP);
      res.pass = 1'b0;
      res.err  = rwp_pkg::ERR_ODD_BITS;
      if (bits[0]) begin
         res.err = rwp_pkg::ERR_ODD_BITS;
      end else if (byte_rate != {3'd0, prod_ff[31:3]}) begin
         res.err = rwp_pkg::ERR_BYTE_RATE;
      end else if ({16'd0, align} != {3'd0, blk_ff[31:3]}) begin
         res.err = rwp_pkg::ERR_ALIGN;
      end else begin
         res.pass = 1'b1;
      end
   end

endmodule

[rtl/riff_wave_pcm_parser.sv]
// a sample, a bad WAVE tag or a non-PCM code is registered in the cycle after its byte;
//   the fmt check outcome is registered in its compare state, after both products
// throughput: one byte per cycle; the last fmt byte holds the input
//   while the shared multiplier forms channels*bits and then rate*that product
// a result waiting under stall holds the input only when it cannot be taken
// synchronous active-high reset clears parse state, check sequencer and output valid
module riff_wave_pcm_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rwp_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rwp_pkg::rsp_type rsp_payload
);

   logic [2:0]  phase_ff, phase_in;
   logic [4:0]  byte_index_ff, byte_index_in;
   logic [31:0] remaining_ff, remaining_in;
   logic [31:0] chunk_tag_ff, chunk_tag_in;
   logic [31:0] gather_ff, gather_in;
   logic [15:0] saved_channels_ff, saved_channels_in;
   logic [31:0] saved_rate_ff, saved_rate_in;
   logic [31:0] saved_byte_rate_ff, saved_byte_rate_in;
   logic [15:0] saved_align_ff, saved_align_in;
   logic [15:0] saved_bits_ff, saved_bits_in;
   logic [7:0]  low_byte_ff, low_byte_in;
   logic        failed_ff, failed_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rwp_pkg::rsp_type rsp_ff, rsp_in;

   logic        accept;
   logic        start;
   logic [7:0]  b;
   logic [2:0]  ph;
   logic [4:0]  idx;
   logic [31:0] rem;
   logic [31:0] rem_dec;
   logic [31:0] g_new;
   logic        launch;
   rwp_pkg::chk_res_type chk;

   rwp_fmt_check u_check (
      .clock     (clock),
      .reset     (reset),
      .launch    (launch),
      .channels  (saved_channels_ff),
      .rate      (saved_rate_ff),
      .bits      (saved_bits_ff),
      .byte_rate (saved_byte_rate_ff),
      .align     (saved_align_ff),
      .res       (chk)
   );

   // handshake
   assign req_stall   = chk.busy || (rsp_valid_ff && rsp_stall);
   assign accept      = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // view of the state as this beat sees it, after a restart
   assign start   = req_payload.start_req;
   assign b       = req_payload.byte_in;
   assign ph      = start ? rwp_pkg::PH_HEADER : phase_ff;
   assign idx     = start ? 5'd0 : byte_index_ff;
   assign rem     = start ? 32'd0 : remaining_ff;
   assign rem_dec = rem - 32'd1;
   assign g_new   = {b, (start ? 24'd0 : gather_ff[31:8])};

   // byte parser
   always_comb begin
      phase_in           = phase_ff;
      byte_index_in      = byte_index_ff;
      remaining_in       = remaining_ff;
      chunk_tag_in       = chunk_tag_ff;
      gather_in          = gather_ff;
      saved_channels_in  = saved_channels_ff;
      saved_rate_in      = saved_rate_ff;
      saved_byte_rate_in = saved_byte_rate_ff;
      saved_align_in     = saved_align_ff;
      saved_bits_in      = saved_bits_ff;
      low_byte_in        = low_byte_ff;
      failed_in          = failed_ff;
      launch             = 1'b0;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_in             = rsp_ff;

      if (accept && (start || !failed_ff)) begin
         phase_in      = ph;
         remaining_in  = rem;
         failed_in     = 1'b0;
         gather_in     = g_new;
         byte_index_in = 5'(idx + 5'd1);
         case (ph)
            rwp_pkg::PH_HEADER: begin
               if (idx == rwp_pkg::IDX_TAG_END) begin
                  chunk_tag_in = g_new;
               end else if (idx >= rwp_pkg::IDX_HDR_END) begin
                  byte_index_in = 5'd0;
                  if (chunk_tag_ff == rwp_pkg::TAG_RIFF) begin
                     phase_in = rwp_pkg::PH_WAVE;
                  end else if (chunk_tag_ff == rwp_pkg::TAG_FMT) begin
                     phase_in     = rwp_pkg::PH_FMT;
                     remaining_in = (g_new > rwp_pkg::FMT_BYTES) ?
                                    g_new - rwp_pkg::FMT_BYTES : 32'd0;
                  end else if (chunk_tag_ff == rwp_pkg::TAG_DATA) begin
                     remaining_in = g_new;
                     phase_in     = (g_new != 32'd0) ? rwp_pkg::PH_DATA : rwp_pkg::PH_HEADER;
                  end else begin
                     remaining_in = g_new;
                     phase_in     = (g_new != 32'd0) ? rwp_pkg::PH_SKIP : rwp_pkg::PH_HEADER;
                  end
               end
            end
            rwp_pkg::PH_WAVE: begin
               if (idx >= rwp_pkg::IDX_WAVE_END) begin
                  byte_index_in = 5'd0;
                  phase_in      = rwp_pkg::PH_HEADER;
                  if (g_new != rwp_pkg::TAG_WAVE) begin
                     failed_in         = 1'b1;
                     rsp_valid_in      = 1'b1;
                     rsp_in            = '0;
                     rsp_in.kind       = rwp_pkg::KIND_ERROR;
                     rsp_in.error_code = rwp_pkg::ERR_NOT_WAVE;
                  end
               end
            end
            rwp_pkg::PH_FMT: begin
               if (idx == rwp_pkg::IDX_FMT_CODE) begin
                  if (g_new[31:16] != rwp_pkg::FMT_PCM) begin
                     failed_in         = 1'b1;
                     rsp_valid_in      = 1'b1;
                     rsp_in            = '0;
                     rsp_in.kind       = rwp_pkg::KIND_ERROR;
                     rsp_in.error_code = rwp_pkg::ERR_NOT_PCM;
                  end
               end else if (idx == rwp_pkg::IDX_FMT_CHAN) begin
                  saved_channels_in = g_new[31:16];
               end else if (idx == rwp_pkg::IDX_FMT_RATE) begin
                  saved_rate_in = g_new;
               end else if (idx == rwp_pkg::IDX_FMT_BRATE) begin
                  saved_byte_rate_in = g_new;
               end else if (idx == rwp_pkg::IDX_FMT_ALIGN) begin
                  saved_align_in = g_new[31:16];
               end else if (idx >= rwp_pkg::IDX_FMT_LAST) begin
                  saved_bits_in = g_new[31:16];
                  byte_index_in = 5'd0;
                  phase_in      = (rem != 32'd0) ? rwp_pkg::PH_SKIP : rwp_pkg::PH_HEADER;
                  launch        = 1'b1;
               end
            end
            rwp_pkg::PH_DATA: begin
               remaining_in = rem_dec;
               if (idx == 5'd0) begin
                  if (rem >= 32'd2) begin
                     low_byte_in   = b;
                     byte_index_in = 5'd1;
                  end else begin
                     byte_index_in = 5'd0;
                  end
               end else begin
                  byte_index_in = 5'd0;
                  rsp_valid_in  = 1'b1;
                  rsp_in        = '0;
                  rsp_in.kind   = rwp_pkg::KIND_SAMPLE;
                  rsp_in.sample = {b, low_byte_ff};
               end
               if (rem_dec == 32'd0) begin
                  phase_in      = rwp_pkg::PH_HEADER;
                  byte_index_in = 5'd0;
               end
            end
            rwp_pkg::PH_SKIP: begin
               remaining_in  = rem_dec;
               byte_index_in = 5'd0;
               if (rem_dec == 32'd0) begin
                  phase_in = rwp_pkg::PH_HEADER;
               end
            end
            default: begin
               phase_in      = rwp_pkg::PH_HEADER;
               byte_index_in = 5'd0;
               remaining_in  = 32'd0;
               gather_in     = 32'd0;
               failed_in     = 1'b0;
            end
         endcase
      end

      // fmt check outcome, no beat is taken while it runs
      if (chk.done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         if (chk.pass) begin
            rsp_in.kind        = rwp_pkg::KIND_FORMAT;
            rsp_in.channels    = saved_channels_ff;
            rsp_in.sample_rate = saved_rate_ff;
            rsp_in.bit_depth   = saved_bits_ff;
         end else begin
            failed_in         = 1'b1;
            rsp_in.kind       = rwp_pkg::KIND_ERROR;
            rsp_in.error_code = chk.err;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= rwp_pkg::PH_HEADER;
         byte_index_ff      <= 5'd0;
         remaining_ff       <= 32'd0;
         chunk_tag_ff       <= 32'd0;
         gather_ff          <= 32'd0;
         saved_channels_ff  <= 16'd0;
         saved_rate_ff      <= 32'd0;
         saved_byte_rate_ff <= 32'd0;
         saved_align_ff     <= 16'd0;
         saved_bits_ff      <= 16'd0;
         low_byte_ff        <= 8'd0;
         failed_ff          <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         phase_ff           <= phase_in;
         byte_index_ff      <= byte_index_in;
         remaining_ff       <= remaining_in;
         chunk_tag_ff       <= chunk_tag_in;
         gather_ff          <= gather_in;
         saved_channels_ff  <= saved_channels_in;
         saved_rate_ff      <= saved_rate_in;
         saved_byte_rate_ff <= saved_byte_rate_in;
         saved_align_ff     <= saved_align_in;
         saved_bits_ff      <= saved_bits_in;
         low_byte_ff        <= low_byte_in;
         failed_ff          <= failed_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

endmodule

[tb/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_BYTES = 500;
   localparam int unsigned IDLE_LIMIT   = 2000;
   localparam int unsigned SQUEEZE_AT   = 200;
   localparam int unsigned SQUEEZE_LEN  = 300;
   localparam int unsigned DRAIN_CYCLES = 12;
   localparam logic [31:0] TAG_LIST     = 32'h5453_494C;

   typedef enum logic [1:0] {
      ROW_MODEL,
      ROW_SILENT,
      ROW_RESULT
   } row_how_type;

   typedef struct packed {
      rwp_pkg::req_type req;
      row_how_type      how;
      rwp_pkg::rsp_type want;
   } byte_row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   rwp_pkg::req_type req_payload;
   logic             rsp_valid;
   logic             rsp_stall;
   rwp_pkg::rsp_type rsp_payload;

   riff_wave_pcm_parser u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // directed bytes: bad WAVE tag, a byte ignored after it, then a short fmt chunk
   // whose format code is not PCM
   byte_row_type directed_rows [23] = '{
      '{'{8'h52, 1'b1}, ROW_MODEL, '0},
      '{'{8'h49, 1'b0}, ROW_MODEL, '0},
      '{'{8'h46, 1'b0}, ROW_MODEL, '0},
      '{'{8'h46, 1'b0}, ROW_MODEL, '0},
      '{'{8'hFF, 1'b0}, ROW_MODEL, '0},
      '{'{8'hFF, 1'b0}, ROW_MODEL, '0},
      '{'{8'hFF, 1'b0}, ROW_MODEL, '0},
      '{'{8'hFF, 1'b0}, ROW_MODEL, '0},
      '{'{8'h57, 1'b0}, ROW_MODEL, '0},
      '{'{8'h41, 1'b0}, ROW_MODEL, '0},
      '{'{8'h56, 1'b0}, ROW_MODEL, '0},
      '{'{8'h00, 1'b0}, ROW_RESULT,
        '{rwp_pkg::KIND_ERROR, 16'sd0, 16'd0, 32'd0, 16'd0, rwp_pkg::ERR_NOT_WAVE}},
      '{'{8'hFF, 1'b0}, ROW_SILENT, '0},
      '{'{8'h66, 1'b1}, ROW_MODEL, '0},
      '{'{8'h6D, 1'b0}, ROW_MODEL, '0},
      '{'{8'h74, 1'b0}, ROW_MODEL, '0},
      '{'{8'h20, 1'b0}, ROW_MODEL, '0},
      '{'{8'h00, 1'b0}, ROW_MODEL, '0},
      '{'{8'h00, 1'b0}, ROW_MODEL, '0},
      '{'{8'h00, 1'b0}, ROW_MODEL, '0},
      '{'{8'h00, 1'b0}, ROW_MODEL, '0},
      '{'{8'h00, 1'b0}, ROW_MODEL, '0},
      '{'{8'h00, 1'b0}, ROW_RESULT,
        '{rwp_pkg::KIND_ERROR, 16'sd0, 16'd0, 32'd0, 16'd0, rwp_pkg::ERR_NOT_PCM}}
   };

   byte_row_type     byte_rows [$];
   rwp_pkg::rsp_type results_due [$];
   bit               file_opening;
   int unsigned      files_built;
   int unsigned      beats_in;
   int unsigned      errors;
   int unsigned      samples_seen;
   int unsigned      formats_seen;
   int unsigned      faults_seen;
   int unsigned      squeeze_cycles;

   // parser mirror state
   logic [2:0]  p_phase  = rwp_pkg::PH_HEADER;
   logic [4:0]  p_index  = '0;
   logic [31:0] p_left   = '0;
   logic [31:0] p_tag    = '0;
   logic [31:0] p_length = '0;
   logic [31:0] p_gather = '0;
   logic [15:0] p_chan   = '0;
   logic [31:0] p_rate   = '0;
   logic [31:0] p_brate  = '0;
   logic [15:0] p_align  = '0;
   logic [7:0]  p_low    = '0;
   logic        p_failed = 1'b0;

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // first failed check latches the parser until the next restart
   function automatic bit fail_parse(input logic [2:0] code, output rwp_pkg::rsp_type res);
      res = '0;
      res.kind = rwp_pkg::KIND_ERROR;
      res.error_code = code;
      p_failed = 1'b1;
      return 1'b1;
   endfunction

   // one byte through the mirror; returns 1 when it yields a result
   function automatic bit parse_byte(input rwp_pkg::req_type beat,
                                     output rwp_pkg::rsp_type res);
      logic [4:0]  pos;
      logic [15:0] bits;
      logic [31:0] blk;
      logic [31:0] prod;
      logic [31:0] left_before;
      bit          got;
      res = '0;
      got = 1'b0;
      if (beat.start_req) begin
         p_phase = rwp_pkg::PH_HEADER;
         p_index = '0;
         p_left = '0;
         p_gather = '0;
         p_failed = 1'b0;
      end else if (p_failed) begin
         return 1'b0;
      end
      p_gather = {beat.byte_in, p_gather[31:8]};
      pos = p_index;
      p_index = pos + 5'd1;
      case (p_phase)
         rwp_pkg::PH_HEADER: begin
            if (pos == rwp_pkg::IDX_TAG_END) begin
               p_tag = p_gather;
            end else if (pos >= rwp_pkg::IDX_HDR_END) begin
               p_length = p_gather;
               p_index = '0;
               if (p_tag == rwp_pkg::TAG_RIFF) begin
                  p_phase = rwp_pkg::PH_WAVE;
               end else if (p_tag == rwp_pkg::TAG_FMT) begin
                  p_phase = rwp_pkg::PH_FMT;
                  p_left = (p_length > rwp_pkg::FMT_BYTES) ?
                           p_length - rwp_pkg::FMT_BYTES : '0;
               end else begin
                  p_left = p_length;
                  if (p_length == '0) p_phase = rwp_pkg::PH_HEADER;
                  else if (p_tag == rwp_pkg::TAG_DATA) p_phase = rwp_pkg::PH_DATA;
                  else p_phase = rwp_pkg::PH_SKIP;
               end
            end
         end
         rwp_pkg::PH_WAVE: begin
            if (pos >= rwp_pkg::IDX_WAVE_END) begin
               p_index = '0;
               p_phase = rwp_pkg::PH_HEADER;
               if (p_gather != rwp_pkg::TAG_WAVE)
                  got = fail_parse(rwp_pkg::ERR_NOT_WAVE, res);
            end
         end
         rwp_pkg::PH_FMT: begin
            if (pos == rwp_pkg::IDX_FMT_CODE) begin
               if (p_gather[31:16] != rwp_pkg::FMT_PCM)
                  got = fail_parse(rwp_pkg::ERR_NOT_PCM, res);
            end else if (pos == rwp_pkg::IDX_FMT_CHAN) begin
               p_chan = p_gather[31:16];
            end else if (pos == rwp_pkg::IDX_FMT_RATE) begin
               p_rate = p_gather;
            end else if (pos == rwp_pkg::IDX_FMT_BRATE) begin
               p_brate = p_gather;
            end else if (pos == rwp_pkg::IDX_FMT_ALIGN) begin
               p_align = p_gather[31:16];
            end else if (pos >= rwp_pkg::IDX_FMT_LAST) begin
               // odd bits, byte rate and align checks land on the last fmt byte, products wrap at 32 bits
               bits = p_gather[31:16];
               blk = {16'd0, p_chan} * {16'd0, bits};
               prod = p_rate * blk;
               p_index = '0;
               p_phase = (p_left != '0) ? rwp_pkg::PH_SKIP : rwp_pkg::PH_HEADER;
               if (bits[0]) begin
                  got = fail_parse(rwp_pkg::ERR_ODD_BITS, res);
               end else if (p_brate != (prod >> 3)) begin
                  got = fail_parse(rwp_pkg::ERR_BYTE_RATE, res);
               end else if ({16'd0, p_align} != (blk >> 3)) begin
                  got = fail_parse(rwp_pkg::ERR_ALIGN, res);
               end else begin
                  res.kind = rwp_pkg::KIND_FORMAT;
                  res.channels = p_chan;
                  res.sample_rate = p_rate;
                  res.bit_depth = bits;
                  got = 1'b1;
               end
            end
         end
         rwp_pkg::PH_DATA: begin
            // low byte first; a lone last byte is dropped
            left_before = p_left;
            p_left = left_before - 32'd1;
            if (pos == '0) begin
               if (left_before >= 32'd2) begin
                  p_low = beat.byte_in;
                  p_index = 5'd1;
               end else begin
                  p_index = '0;
               end
            end else begin
               res.kind = rwp_pkg::KIND_SAMPLE;
               res.sample = {beat.byte_in, p_low};
               p_index = '0;
               got = 1'b1;
            end
            if (p_left == '0) begin
               p_phase = rwp_pkg::PH_HEADER;
               p_index = '0;
            end
         end
         rwp_pkg::PH_SKIP: begin
            p_left = p_left - 32'd1;
            p_index = '0;
            if (p_left == '0) p_phase = rwp_pkg::PH_HEADER;
         end
         default: begin
            p_phase = rwp_pkg::PH_HEADER;
            p_index = '0;
            p_left = '0;
            p_gather = '0;
            p_failed = 1'b0;
         end
      endcase
      return got;
   endfunction

   // stream building
   function automatic void push_byte(input logic [7:0] b, input bit restart = 1'b0);
      byte_row_type row;
      row = '0;
      row.req.byte_in = b;
      row.req.start_req = restart | file_opening;
      row.how = ROW_MODEL;
      file_opening = 1'b0;
      byte_rows.push_back(row);
   endfunction

   function automatic void push_half(input logic [15:0] h);
      push_byte(h[7:0]);
      push_byte(h[15:8]);
   endfunction

   function automatic void push_word(input logic [31:0] w);
      push_half(w[15:0]);
      push_half(w[31:16]);
   endfunction

   function automatic void add_fmt_chunk(input bit broken);
      logic [15:0] code;
      logic [15:0] chan;
      logic [15:0] bits;
      logic [15:0] align;
      logic [31:0] rate;
      logic [31:0] brate;
      logic [31:0] blk;
      logic [31:0] declared;
      code = rwp_pkg::FMT_PCM;
      case ($urandom_range(0, 7))
         0: chan = 16'd0;
         1: chan = 16'hFFFF;
         2: chan = 16'($urandom_range(3, 8));
         default: chan = 16'($urandom_range(1, 2));
      endcase
      case ($urandom_range(0, 7))
         0: bits = 16'hFFFE;
         1: bits = 16'd0;
         default: bits = 16'(8 * $urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 5))
         0: rate = 32'd0;
         1: rate = 32'hFFFF_FFFF;
         2: rate = $urandom;
         default: rate = $urandom_range(8000, 96000);
      endcase
      blk = {16'd0, chan} * {16'd0, bits};
      brate = (rate * blk) >> 3;
      align = blk[18:3];
      if (broken) begin
         case ($urandom_range(0, 3))
            0: code = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(2, 65535));
            1: bits = bits | 16'd1;
            2: brate = brate + $urandom_range(1, 255);
            default: align = align + 16'd1;
         endcase
      end
      case ($urandom_range(0, 5))
         0: declared = $urandom_range(0, 15);
         1: declared = 32'd16 + $urandom_range(1, 5);
         default: declared = 32'd16;
      endcase
      push_word(rwp_pkg::TAG_FMT);
      push_word(declared);
      push_half(code);
      push_half(chan);
      push_word(rate);
      push_word(brate);
      push_half(align);
      push_half(bits);
      // bytes past the 16 fmt bytes get skipped
      if (declared > 32'd16) repeat (declared - 32'd16) push_byte(8'($urandom_range(0, 255)));
   endfunction

   function automatic void add_data_chunk(input bit cut);
      int unsigned declared;
      int unsigned sent;
      declared = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
      sent = declared;
      if (cut) begin
         declared = declared + $urandom_range(1, 8);
         sent = $urandom_range(0, sent);
      end
      push_word(rwp_pkg::TAG_DATA);
      push_word(declared);
      // lean on the sample extremes
      repeat (sent) begin
         case ($urandom_range(0, 5))
            0: push_byte(8'h00);
            1: push_byte(8'hFF);
            2: push_byte(8'h7F);
            3: push_byte(8'h80);
            default: push_byte(8'($urandom_range(0, 255)));
         endcase
      end
   endfunction

   function automatic void add_other_chunk();
      int unsigned declared;
      declared = $urandom_range(0, 6);
      push_word(($urandom_range(0, 1) == 0) ? TAG_LIST : $urandom);
      push_word(declared);
      repeat (declared) push_byte(8'($urandom_range(0, 255)));
   endfunction

   // one file: mostly well formed, some noise, bad tags, broken fmt or cut data
   function automatic void add_file();
      int unsigned shape;
      int unsigned n;
      files_built++;
      file_opening = 1'b1;
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
         n = $urandom_range(4, 24);
         repeat (n) push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end else if (shape == 2) begin
         push_word(rwp_pkg::TAG_RIFF);
         push_word($urandom);
         push_word($urandom);
         n = $urandom_range(0, 2);
         repeat (n) push_byte(8'($urandom_range(0, 255)));
      end else begin
         // shape 1 leaves out the RIFF wrapper
         if (shape != 1) begin
            push_word(rwp_pkg::TAG_RIFF);
            push_word($urandom);
            push_word(rwp_pkg::TAG_WAVE);
         end
         add_fmt_chunk(shape == 3);
         n = $urandom_range(1, 3);
         repeat (n) begin
            case ($urandom_range(0, 4))
               0: add_fmt_chunk(1'b0);
               1: add_other_chunk();
               default: add_data_chunk(shape == 4);
            endcase
         end
      end
   endfunction

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // byte sender: bursts with random gaps
   initial begin : feed
      int unsigned      pos;
      int unsigned      burst_left;
      int unsigned      gap_left;
      byte_row_type     row;
      rwp_pkg::rsp_type res;
      req_valid <= 1'b0;
      req_payload <= '0;
      foreach (directed_rows[i]) byte_rows.push_back(directed_rows[i]);
      while (byte_rows.size() < $size(directed_rows) + RANDOM_BYTES) add_file();
      pos = 0;
      burst_left = $urandom_range(1, 30);
      gap_left = 0;
      do @(posedge clock); while (reset);
      while (pos < byte_rows.size()) begin
         @(posedge clock);
         if (req_valid && !req_stall) begin
            row = byte_rows[pos];
            if (row.how == ROW_MODEL) begin
               if (parse_byte(row.req, res)) results_due.push_back(res);
            end else begin
               void'(parse_byte(row.req, res));
               if (row.how == ROW_RESULT) results_due.push_back(row.want);
            end
            pos++;
            beats_in++;
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
         // a stalled beat stays put
         if (!(req_valid && req_stall)) begin
            if (pos < byte_rows.size() && gap_left == 0) begin
               req_valid <= 1'b1;
               req_payload <= byte_rows[pos].req;
            end else begin
               req_valid <= 1'b0;
               if (gap_left > 0) gap_left--;
            end
         end
      end
      while (results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d bytes: %0d directed, rest from %0d generated files",
               beats_in, $size(directed_rows), files_built);
      $display("checked %0d samples, %0d formats, %0d parse errors; one %0d-cycle hold-off",
               samples_seen, formats_seen, faults_seen, squeeze_cycles);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // result receiver: stall pattern of its own plus one long hold-off
   initial begin : drain
      int unsigned style;
      int unsigned style_left;
      int unsigned hold_left;
      bit          squeezed;
      style = 0;
      style_left = 0;
      hold_left = 0;
      squeezed = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!squeezed && beats_in >= SQUEEZE_AT) begin
            hold_left = SQUEEZE_LEN;
            squeezed = 1'b1;
         end
         if (style_left == 0) begin
            style = $urandom_range(0, 3);
            style_left = $urandom_range(8, 64);
         end
         style_left--;
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
            squeeze_cycles++;
         end else begin
            case (style)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= style_left[2];
            endcase
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      rwp_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         case (rsp_payload.kind)
            rwp_pkg::KIND_SAMPLE: samples_seen++;
            rwp_pkg::KIND_FORMAT: formats_seen++;
            default: faults_seen++;
         endcase
         if (results_due.size() == 0) begin
            flag_mismatch("result with nothing pending, kind", 32'(rsp_payload.kind), 'x);
         end else begin
            want = results_due.pop_front();
            if (rsp_payload.kind != want.kind)
               flag_mismatch("kind", 32'(rsp_payload.kind), 32'(want.kind));
            if (rsp_payload.sample != want.sample)
               flag_mismatch("sample", 32'(rsp_payload.sample), 32'(want.sample));
            if (rsp_payload.channels != want.channels)
               flag_mismatch("channels", 32'(rsp_payload.channels), 32'(want.channels));
            if (rsp_payload.sample_rate != want.sample_rate)
               flag_mismatch("sample_rate", rsp_payload.sample_rate, want.sample_rate);
            if (rsp_payload.bit_depth != want.bit_depth)
               flag_mismatch("bit_depth", 32'(rsp_payload.bit_depth), 32'(want.bit_depth));
            if (rsp_payload.error_code != want.error_code)
               flag_mismatch("error_code", 32'(rsp_payload.error_code),
                             32'(want.error_code));
         end
      end
   end

   // watchdog on cycles with no beat on either side
   initial begin : watchdog
      int unsigned idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
         else idle++;
      end
      $display("timeout after %0d idle cycles, %0d results pending", idle,
               results_due.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule

[filelist.f]
rtl/rwp_pkg.sv
rtl/rwp_fmt_check.sv
rtl/riff_wave_pcm_parser.sv
tb/tb.sv
